@@ design/atrsp_pkg.sv @@
package atrsp_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_BYTES_DEF = 64;
  localparam int NAME_MAX_DEF     = 31;

  // The width of the transmit flag field follows the channel count.
  localparam int CHANNELS = 5;

  // Header bytes of a request that are not part of the path.
  localparam int HTTP_HDR_BYTES = 42;

  // Input actions.
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_CLR_RST = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  // Result events.
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_REQ     = 3'd1;
  localparam logic [2:0] EV_CLOSED  = 3'd2;
  localparam logic [2:0] EV_MODRST  = 3'd3;
  localparam logic [2:0] EV_GARBAGE = 3'd4;
  localparam logic [2:0] EV_BAD     = 3'd5;

  // Literal selectors used while decoding a request.
  localparam logic [1:0] LIT_IPD   = 2'd0;
  localparam logic [1:0] LIT_COMMA = 2'd1;
  localparam logic [1:0] LIT_GET   = 2'd2;

  // Characters.
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CH_END = 8'(8'h30 + CHANNELS);

  // Tail patterns, last character in the low byte.
  localparam logic [71:0] TXT_RST    = "rst cause";
  localparam logic [39:0] TXT_IPD    = "+IPD,";
  localparam logic [55:0] TXT_CLOSED = ",CLOSED";
  localparam logic [31:0] TXT_HTTP   = "HTTP";
  localparam logic [47:0] TXT_GET    = ":GET /";

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          event_res;
    logic [2:0]          channel;
    logic [7:0]          name_char;
    logic                name_valid;
    logic [15:0]         ignore_count;
    logic [CHANNELS-1:0] transmit_flags;
    logic                reset_pending;
    logic                last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic step;
    logic scan_start;
    logic adv;
    logic num_dig;
    logic save_id;
    logic save_len;
    logic path_start;
    logic path_adv;
    logic path_done;
    logic emit_start;
    logic load_bad;
    logic load_name;
  } atrsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       step_decode;
    logic       out_free;
    logic [7:0] ch;
    logic       p_end;
    logic       id_ok;
    logic       emit_zero;
    logic       emit_last;
  } atrsp_stat_t;

  // Character k of a decode literal.
  function automatic logic [7:0] lit_char(input logic [1:0] lid, input logic [2:0] k);
    logic [47:0] s;
    begin
      case (lid)
        LIT_IPD:   s = {TXT_IPD, 8'h00};
        LIT_COMMA: s = {CH_COMMA, 40'h0};
        default:   s = TXT_GET;
      endcase
      lit_char = 8'(s >> (8 * (5 - int'(k))));
    end
  endfunction

  // Index of the final character of a decode literal.
  function automatic logic [2:0] lit_last(input logic [1:0] lid);
    case (lid)
      LIT_IPD:   lit_last = 3'd4;
      LIT_COMMA: lit_last = 3'd0;
      default:   lit_last = 3'd5;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_0) && (c <= CH_9);
  endfunction

  // Characters that end a request path.
  function automatic logic is_end(input logic [7:0] c);
    is_end = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

@@ design/atrsp_ram.sv @@
module atrsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/atrsp_dp.sv @@
module atrsp_dp
  import atrsp_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int NAME_MAX     = NAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  in_word_t    in_data,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output out_word_t   out_data,
  input  atrsp_cmd_t  cmd,
  output atrsp_stat_t stat
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int PW = $clog2(WINDOW_BYTES + 1);
  localparam int EW = $clog2(NAME_MAX + 1);

  in_word_t                inw;
  logic                    en;
  logic [AW-1:0]           wp;
  logic [WINDOW_BYTES-1:0] vld;
  logic [71:0]             tail;
  logic [1:0]              run;
  logic                    phase;
  logic                    rf;
  logic [CHANNELS-1:0]     flags;
  logic [PW-1:0]           p;
  logic [15:0]             acc;
  logic [15:0]             id;
  logic [15:0]             len;
  logic [PW-1:0]           start;
  logic [PW-1:0]           plen;
  logic [15:0]             ign;
  logic [EW-1:0]           e;
  logic                    rvld;
  logic [7:0]              rdata;
  logic [AW-1:0]           raddr;
  logic [AW:0]             rsum;

  // Step results, worked out from the latched word.
  logic [7:0]          b;
  logic [1:0]          run_b;
  logic [71:0]         tail_n;
  logic [7:0]          cdig;
  logic [2:0]          cid;
  logic [2:0]          ev;
  logic [2:0]          chn;
  logic                rf_n;
  logic [CHANNELS-1:0] fl_n;
  logic                rp;
  logic                phase_n;
  logic [1:0]          run_n;
  logic                do_clr;
  logic                wr;
  logic                dec;

  logic [EW-1:0] emitn;
  logic [16:0]   need;
  logic [16:0]   len17;
  logic          load_any;

  // Window store: a circular buffer with one valid bit per entry.
  atrsp_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_win (
    .clk  (clk),
    .we   (cmd.step && wr),
    .waddr(wp),
    .wdata(b),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Logical window index p maps to the entry p places on from the write pointer.
  always_comb begin
    rsum = {1'b0, wp} + (AW + 1)'(p[AW-1:0]);
    if (rsum >= (AW + 1)'(WINDOW_BYTES)) begin
      raddr = AW'(rsum - (AW + 1)'(WINDOW_BYTES));
    end else begin
      raddr = AW'(rsum);
    end
  end

  // Byte step, acknowledge and reset-clear actions.
  always_comb begin
    b       = inw.rx_byte;
    tail_n  = {tail[63:0], b};
    cdig    = tail_n[63:56];
    cid     = 3'(cdig - CH_0);
    ev      = EV_NONE;
    chn     = 3'd0;
    rf_n    = rf;
    fl_n    = flags;
    rp      = rf;
    phase_n = phase;
    run_n   = run;
    do_clr  = 1'b0;
    wr      = 1'b0;
    dec     = 1'b0;
    if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
      run_b = run;
    end else if (b < CH_SPACE || b > CH_TILDE) begin
      run_b = run + 2'd1;
    end else begin
      run_b = 2'd0;
    end
    if (inw.action == ACT_BYTE && en) begin
      wr    = 1'b1;
      run_n = run_b;
      if (run_b == 2'd3) begin
        rf_n    = 1'b1;
        run_n   = 2'd0;
        phase_n = 1'b0;
        do_clr  = 1'b1;
        ev      = EV_GARBAGE;
      end else if (tail_n == TXT_RST) begin
        rf_n    = 1'b1;
        phase_n = 1'b0;
        do_clr  = 1'b1;
        ev      = EV_MODRST;
      end else if (!phase) begin
        if (b == CH_COMMA && tail_n[39:0] == TXT_IPD) begin
          phase_n = 1'b1;
        end else if (b == CH_D && tail_n[55:0] == TXT_CLOSED &&
                     cdig >= CH_0 && cdig < CH_CH_END) begin
          fl_n = flags & ~(CHANNELS'(1) << cid);
          ev   = EV_CLOSED;
          chn  = cid;
        end
      end else if (tail_n[31:0] == TXT_HTTP) begin
        phase_n = 1'b0;
        dec     = 1'b1;
      end
      rp = rf_n;
    end else if (inw.action == ACT_ACK) begin
      rp = rf;
      if (rf) begin
        fl_n = '0;
        rf_n = 1'b0;
      end
    end else if (inw.action == ACT_CLR_RST) begin
      rf_n = 1'b0;
      rp   = 1'b0;
    end
  end

  // Path length and skip count.
  always_comb begin
    if (32'(plen) < NAME_MAX) begin
      emitn = EW'(plen);
    end else begin
      emitn = EW'(NAME_MAX);
    end
    need  = 17'(HTTP_HDR_BYTES) + 17'(plen);
    len17 = {1'b0, len};
  end

  // Status toward the controller.
  always_comb begin
    stat.step_decode = dec;
    stat.out_free    = !out_valid || !out_stall;
    stat.p_end       = p >= PW'(WINDOW_BYTES);
    stat.ch          = (rvld && !stat.p_end) ? rdata : CH_NUL;
    stat.id_ok       = id < 16'(CHANNELS);
    stat.emit_zero   = plen == '0;
    stat.emit_last   = e == emitn - EW'(1);
  end

  assign load_any = (cmd.step && !dec) || cmd.load_bad || cmd.load_name;

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      en        <= 1'b0;
      wp        <= '0;
      vld       <= '0;
      tail      <= '0;
      run       <= 2'd0;
      phase     <= 1'b0;
      rf        <= 1'b0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        en <= cfg_data;
      end
      if (cmd.step) begin
        run   <= run_n;
        phase <= phase_n;
        rf    <= rf_n;
        flags <= fl_n;
        if (wr) begin
          wp <= (wp == AW'(WINDOW_BYTES - 1)) ? '0 : wp + AW'(1);
        end
        // A clearing step empties the window, the new byte included.
        if (do_clr) begin
          vld  <= '0;
          tail <= '0;
        end else if (wr) begin
          vld[wp] <= 1'b1;
          tail    <= tail_n;
        end
      end
      if (cmd.path_done) begin
        flags <= flags | (CHANNELS'(1) << id[2:0]);
      end
      if (cmd.load_bad || (cmd.load_name && (stat.emit_zero || stat.emit_last))) begin
        vld  <= '0;
        tail <= '0;
      end
      if (load_any) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rvld <= vld[raddr];
    if (cmd.take) begin
      inw <= in_data;
    end
    if (cmd.scan_start) begin
      p   <= '0;
      acc <= '0;
    end
    if (cmd.adv || cmd.path_adv) begin
      p <= p + PW'(1);
    end
    if (cmd.path_adv) begin
      plen <= plen + PW'(1);
    end
    if (cmd.num_dig) begin
      acc <= (acc << 3) + (acc << 1) + {8'h00, stat.ch - CH_0};
    end
    if (cmd.save_id) begin
      id  <= acc;
      acc <= '0;
    end
    if (cmd.save_len) begin
      len <= acc;
      acc <= '0;
    end
    if (cmd.path_start) begin
      p     <= p + PW'(1);
      start <= p + PW'(1);
      plen  <= '0;
    end
    if (cmd.path_done) begin
      ign <= (len17 > need) ? 16'(len17 - need) : 16'd0;
    end
    if (cmd.emit_start) begin
      p <= start;
      e <= '0;
    end
    if (cmd.load_name) begin
      p <= p + PW'(1);
      e <= e + EW'(1);
    end
    if (cmd.step && !dec) begin
      out_data <= '{event_res: ev, channel: chn, name_char: 8'h00, name_valid: 1'b0,
                    ignore_count: 16'd0, transmit_flags: fl_n, reset_pending: rp,
                    last: 1'b1};
    end else if (cmd.load_bad) begin
      out_data <= '{event_res: EV_BAD, channel: 3'd0, name_char: 8'h00, name_valid: 1'b0,
                    ignore_count: 16'd0, transmit_flags: flags, reset_pending: rf,
                    last: 1'b1};
    end else if (cmd.load_name) begin
      out_data <= '{event_res: EV_REQ, channel: id[2:0],
                    name_char: stat.emit_zero ? 8'h00 : stat.ch,
                    name_valid: !stat.emit_zero, ignore_count: ign,
                    transmit_flags: flags, reset_pending: rf,
                    last: stat.emit_zero || stat.emit_last};
    end
  end

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_any |-> stat.out_free) else $error("result loaded over a waiting word");

  // A path character only ever rides on a parsed request.
  a_name_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.name_valid |-> out_data.event_res == EV_REQ)
    else $error("path character on a non-request word");

  // The bad byte run never rests at three.
  a_run: assert property (@(posedge clk) disable iff (rst)
    run != 2'd3) else $error("bad byte run left at three");

  // A malformed request leaves the window empty.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load_bad |=> vld == '0) else $error("window not cleared after a bad request");

endmodule

@@ design/atrsp_ctrl.sv @@
module atrsp_ctrl
  import atrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  atrsp_stat_t stat,
  output atrsp_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_RD, S_EV, S_ERD, S_EEV} state_t;
  typedef enum logic [1:0] {D_FIND, D_LIT, D_NUM, D_PATH} dph_t;

  state_t     state, state_next;
  dph_t       dph, dph_next;
  logic [1:0] lid, lid_next;
  logic [2:0] k, k_next;
  logic       sel, sel_next;
  logic       seen, seen_next;
  logic       bad;
  logic [7:0] c;

  assign in_stall = state != S_IDLE;
  assign c        = stat.ch;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    dph_next   = dph;
    lid_next   = lid;
    k_next     = k;
    sel_next   = sel;
    seen_next  = seen;
    bad        = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.step_decode) begin
          cmd.step       = 1'b1;
          cmd.scan_start = 1'b1;
          dph_next       = D_FIND;
          state_next     = S_RD;
        end else if (stat.out_free) begin
          cmd.step   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        state_next = S_EV;
      end
      S_EV: begin
        state_next = S_RD;
        case (dph)
          D_FIND: begin
            if (stat.p_end) begin
              bad = 1'b1;
            end else if (c == CH_PLUS) begin
              dph_next = D_LIT;
              lid_next = LIT_IPD;
              k_next   = 3'd0;
            end else begin
              cmd.adv = 1'b1;
            end
          end
          D_LIT: begin
            if (c != lit_char(lid, k)) begin
              bad = 1'b1;
            end else if (k == lit_last(lid)) begin
              case (lid)
                LIT_IPD: begin
                  cmd.adv   = 1'b1;
                  dph_next  = D_NUM;
                  sel_next  = 1'b0;
                  seen_next = 1'b0;
                end
                LIT_COMMA: begin
                  cmd.adv   = 1'b1;
                  dph_next  = D_NUM;
                  sel_next  = 1'b1;
                  seen_next = 1'b0;
                end
                default: begin
                  if (stat.id_ok) begin
                    cmd.path_start = 1'b1;
                    dph_next       = D_PATH;
                  end else begin
                    bad = 1'b1;
                  end
                end
              endcase
            end else begin
              cmd.adv = 1'b1;
              k_next  = k + 3'd1;
            end
          end
          D_NUM: begin
            if (is_digit(c)) begin
              cmd.num_dig = 1'b1;
              cmd.adv     = 1'b1;
              seen_next   = 1'b1;
            end else if (!seen) begin
              bad = 1'b1;
            end else begin
              cmd.save_len = sel;
              cmd.save_id  = !sel;
              dph_next     = D_LIT;
              lid_next     = sel ? LIT_GET : LIT_COMMA;
              k_next       = 3'd0;
            end
          end
          default: begin
            if (is_end(c)) begin
              cmd.path_done  = 1'b1;
              cmd.emit_start = 1'b1;
              state_next     = S_ERD;
            end else begin
              cmd.path_adv = 1'b1;
            end
          end
        endcase
        // A malformed request drops all other work and reports once.
        if (bad) begin
          cmd          = '0;
          dph_next     = dph;
          lid_next     = lid;
          k_next       = k;
          sel_next     = sel;
          seen_next    = seen;
          cmd.load_bad = stat.out_free;
          state_next   = stat.out_free ? S_IDLE : S_EV;
        end
      end
      S_ERD: begin
        if (stat.emit_zero) begin
          if (stat.out_free) begin
            cmd.load_name = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_EEV;
        end
      end
      S_EEV: begin
        if (stat.out_free) begin
          cmd.load_name = 1'b1;
          state_next    = stat.emit_last ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dph   <= D_FIND;
      lid   <= LIT_IPD;
      k     <= 3'd0;
      sel   <= 1'b0;
      seen  <= 1'b0;
    end else begin
      state <= state_next;
      dph   <= dph_next;
      lid   <= lid_next;
      k     <= k_next;
      sel   <= sel_next;
      seen  <= seen_next;
    end
  end

  // A step is only issued from the step state.
  a_step_state: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> state == S_STEP) else $error("step issued outside step state");

  // Emission follows a completed path scan.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.path_done |=> state == S_ERD) else $error("path scan did not lead to emission");

endmodule

@@ design/at_response_stream_parser.sv @@
// Channel  Direction  Handshake           Word
// in       input      in_valid/in_stall   in_word_t (action, rx_byte)
// out      output     out_valid/out_stall out_word_t (one result per word)
// cfg      input      cfg_we              cfg_data (parse enable)
//
// An ordinary word is accepted in the idle state; its byte step is applied in the step state once the output is free.
// A word that completes a request scans the window one position at a time, with a read
// state and an evaluate state per position, up to the end of the path, then reads and
// emits each path character in turn while the output is free.
// Reset is synchronous and active high; it empties the window through valid bits.
// A stalled output holds the result register; the next word is still accepted.
module at_response_stream_parser
  import atrsp_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int NAME_MAX     = NAME_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  atrsp_cmd_t  cmd;
  atrsp_stat_t stat;

  atrsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  atrsp_dp #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .NAME_MAX    (NAME_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import atrsp_pkg::*;

  localparam int WIN        = 64;
  localparam int PATH_LIMIT = 31;
  localparam int CYCLE_CAP  = 600000;

  // Tracks the parser state and holds the words the block should send back.
  class parser_scoreboard;
    logic [7:0]          win [WIN];
    bit                  phase;
    bit [1:0]            run;
    bit [CHANNELS-1:0]   flags;
    bit                  rflag;
    bit                  enable;
    out_word_t           expected_words [$];
    out_word_t           step_words [$];
    int                  errors;
    int                  words_in;
    int                  words_out;
    int                  event_count [8];

    function void clear_all();
      foreach (win[i]) win[i] = 8'h00;
      phase = 0;
      run = 0;
      flags = '0;
      rflag = 0;
      enable = 0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      foreach (event_count[i]) event_count[i] = 0;
    endfunction

    function void add_word(logic [2:0] ev, logic [2:0] ch, logic [7:0] nc, bit nv,
                           logic [15:0] ign, bit rp);
      out_word_t w;
      w.event_res      = ev;
      w.channel        = ch;
      w.name_char      = nc;
      w.name_valid     = nv;
      w.ignore_count   = ign;
      w.transmit_flags = flags;
      w.reset_pending  = rp;
      w.last           = 0;
      step_words.push_back(w);
    endfunction

    function void wipe_window();
      foreach (win[i]) win[i] = 8'h00;
    endfunction

    function bit tail_is(string s);
      for (int i = 0; i < s.len(); i++)
        if (win[WIN - s.len() + i] != s[i]) return 0;
      return 1;
    endfunction

    function logic [7:0] byte_at(int p);
      return (p < WIN) ? win[p] : 8'h00;
    endfunction

    function bit match_text(inout int p, input string s);
      for (int i = 0; i < s.len(); i++) begin
        if (byte_at(p) != s[i]) return 0;
        p++;
      end
      return 1;
    endfunction

    function bit read_number(inout int p, output logic [15:0] v);
      int cnt;
      cnt = 0;
      v = 0;
      while (byte_at(p) >= CH_0 && byte_at(p) <= CH_9) begin
        v = 16'(v * 10 + (byte_at(p) - CH_0));
        p++;
        cnt++;
      end
      return cnt > 0;
    endfunction

    // Decodes "+IPD,<id>,<len>:GET /<path>" starting at the first plus sign.
    function void decode_request();
      int          p;
      int          start;
      int          plen;
      int          emit;
      logic [15:0] id;
      logic [15:0] len;
      logic [7:0]  c;
      int          ign;
      p = 0;
      while (p < WIN && win[p] != CH_PLUS) p++;
      if (p >= WIN || !match_text(p, "+IPD,") || !read_number(p, id) ||
          !match_text(p, ",") || !read_number(p, len) || !match_text(p, ":GET /") ||
          id >= CHANNELS) begin
        wipe_window();
        add_word(EV_BAD, 0, 0, 0, 0, rflag);
        return;
      end
      start = p;
      c = byte_at(p);
      while (!(c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_LF ||
               c == CH_VT || c == CH_FF || c == CH_CR)) begin
        p++;
        c = byte_at(p);
      end
      plen = p - start;
      ign = (int'(len) > HTTP_HDR_BYTES + plen) ? int'(len) - HTTP_HDR_BYTES - plen : 0;
      flags[id] = 1;
      emit = (plen < PATH_LIMIT) ? plen : PATH_LIMIT;
      if (emit == 0) add_word(EV_REQ, id[2:0], 0, 0, 16'(ign), rflag);
      for (int i = 0; i < emit; i++)
        add_word(EV_REQ, id[2:0], win[start + i], 1, 16'(ign), rflag);
      wipe_window();
    endfunction

    function void predict_byte(logic [7:0] b);
      logic [7:0] c;
      for (int i = 0; i < WIN - 1; i++) win[i] = win[i + 1];
      win[WIN - 1] = b;
      if (b != CH_CR && b != CH_LF && b != CH_NUL)
        run = (b < CH_SPACE || b > CH_TILDE) ? run + 2'd1 : 2'd0;
      if (run == 3) begin
        rflag = 1;
        run = 0;
        phase = 0;
        wipe_window();
        add_word(EV_GARBAGE, 0, 0, 0, 0, rflag);
        return;
      end
      if (tail_is("rst cause")) begin
        rflag = 1;
        phase = 0;
        wipe_window();
        add_word(EV_MODRST, 0, 0, 0, 0, rflag);
        return;
      end
      if (!phase) begin
        if (b == CH_COMMA && tail_is("+IPD,")) begin
          phase = 1;
        end else if (b == CH_D && tail_is(",CLOSED")) begin
          c = win[WIN - 8];
          if (c >= CH_0 && c < CH_CH_END) begin
            flags[c - CH_0] = 0;
            add_word(EV_CLOSED, 3'(c - CH_0), 0, 0, 0, rflag);
            return;
          end
        end
      end else if (tail_is("HTTP")) begin
        phase = 0;
        decode_request();
        return;
      end
      add_word(EV_NONE, 0, 0, 0, 0, rflag);
    endfunction

    // Works out the words caused by one accepted input word.
    function void note_input(in_word_t w);
      bit old;
      step_words.delete();
      words_in++;
      if (w.action == ACT_BYTE && enable) begin
        predict_byte(w.rx_byte);
      end else if (w.action == ACT_ACK) begin
        old = rflag;
        if (old) begin
          flags = '0;
          rflag = 0;
        end
        add_word(EV_NONE, 0, 0, 0, 0, old);
      end else begin
        if (w.action == ACT_CLR_RST) rflag = 0;
        add_word(EV_NONE, 0, 0, 0, 0, rflag);
      end
      step_words[step_words.size() - 1].last = 1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      words_out++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      event_count[exp.event_res]++;
      if (got.event_res !== exp.event_res) begin
        $error("event_res expected %0d got %0d", exp.event_res, got.event_res); errors++;
      end
      if (got.channel !== exp.channel) begin
        $error("channel expected %0d got %0d", exp.channel, got.channel); errors++;
      end
      if (got.name_char !== exp.name_char) begin
        $error("name_char expected %h got %h", exp.name_char, got.name_char); errors++;
      end
      if (got.name_valid !== exp.name_valid) begin
        $error("name_valid expected %0d got %0d", exp.name_valid, got.name_valid); errors++;
      end
      if (got.ignore_count !== exp.ignore_count) begin
        $error("ignore_count expected %0d got %0d", exp.ignore_count, got.ignore_count);
        errors++;
      end
      if (got.transmit_flags !== exp.transmit_flags) begin
        $error("transmit_flags expected %b got %b", exp.transmit_flags, got.transmit_flags);
        errors++;
      end
      if (got.reset_pending !== exp.reset_pending) begin
        $error("reset_pending expected %0d got %0d", exp.reset_pending, got.reset_pending);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last expected %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_we;
  logic      cfg_data;

  parser_scoreboard sb;
  bit  quiet;
  int  long_hold;
  int  rx_hold;
  int  cycles;

  at_response_stream_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[at_response_stream_parser] ERROR");
      $finish;
    end
  end

  // Result side: check each accepted word, then stall for a random count.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        rx_hold = quiet ? 0 : $urandom_range(0, 7);
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1;
      end else if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // Offers one word after a random gap and waits until it is taken.
  task automatic send_word(logic [1:0] act, logic [7:0] b);
    in_word_t w;
    int gap;
    w.action = act;
    w.rx_byte = b;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(ACT_BYTE, s[i]);
  endtask

  // The block is idle once every word is back and the longest decode is over.
  task automatic set_enable(bit v);
    @(posedge clk);
    in_valid <= 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.enable = v;
  endtask

  function automatic string path_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%c", 8'($urandom_range(8'h21, 8'h7E)))};
    return s;
  endfunction

  // A request with random channel, length and path; sometimes one byte is broken.
  task automatic send_request();
    string s;
    int    k;
    s = $sformatf("+IPD,%0d,%0d:GET /%s HTTP", $urandom_range(0, 6),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999999) : $urandom_range(0, 200),
                  path_text($urandom_range(0, 8)));
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, s.len() - 6);
      s[k] = 8'($urandom_range(8'h21, 8'h7E));
    end
    send_text(s);
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    cycles = 0;
    long_hold = 0;
    rx_hold = 0;
    quiet = 0;
    rst <= 1;
    in_valid <= 0;
    in_data <= '0;
    cfg_we <= 0;
    cfg_data <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Disabled parser: bytes are ignored, as is the unused action.
    send_word(ACT_BYTE, 8'h2B);
    send_word(ACT_NOP, 8'hFF);
    set_enable(1);

    // Directed words: a long path, a bad channel, close, module reset, acks, garbage, reset clear, no-op.
    send_text({"+IPD,1,300:GET /", path_text(32), " HTTP"});
    send_text("+IPD,5,1:GET /a HTTP");
    send_text("3,CLOSED");
    send_text("rst cause");
    send_word(ACT_ACK, 8'h00);
    send_word(ACT_ACK, 8'h00);
    send_word(ACT_BYTE, 8'h01);
    send_word(ACT_BYTE, 8'h0D);
    send_word(ACT_BYTE, 8'h80);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_CLR_RST, 8'hAA);
    send_word(ACT_NOP, 8'h55);

    // Back-pressure: the result side holds off while a request streams in.
    quiet = 1;
    long_hold = 500;
    send_text("+IPD,2,77:GET / HTTP");
    quiet = 0;

    set_enable(0);
    send_word(ACT_BYTE, 8'h7F);
    set_enable(1);

    // Random part: mostly well-formed traffic, with noise and broken requests.
    while (sb.words_in < 128) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_request();
        4:          send_text($sformatf("%0d,CLOSED", $urandom_range(0, 9)));
        5:          send_word(2'($urandom_range(1, 3)), 8'($urandom));
        6:          if ($urandom_range(0, 3) == 0) send_text("rst cause");
                    else send_word(ACT_BYTE, 8'($urandom));
        7:          for (int j = 0; j < 3; j++) send_word(ACT_BYTE, 8'($urandom));
        8:          quiet = ~quiet;
        default:    send_text({"OK\r\n", path_text($urandom_range(1, 4))});
      endcase
    end
    quiet = 0;
    set_enable(0);

    @(posedge clk);
    in_valid <= 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d words, checked %0d results: %0d requests, %0d closes,",
             sb.words_in, sb.words_out, sb.event_count[EV_REQ], sb.event_count[EV_CLOSED]);
    $display("%0d module resets, %0d garbage resets, %0d malformed requests.",
             sb.event_count[EV_MODRST], sb.event_count[EV_GARBAGE], sb.event_count[EV_BAD]);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("[at_response_stream_parser] OK");
    end else begin
      $display("[at_response_stream_parser] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/atrsp_pkg.sv
design/atrsp_ram.sv
design/atrsp_dp.sv
design/atrsp_ctrl.sv
design/at_response_stream_parser.sv
tb/testbench.sv
